>>> design/etd_pkg.sv
// Shared types and constants for the exclusive-time-by-depth block.
// Used by etd_calc and exclusive_time_by_depth; depends on nothing.
`default_nettype none

package etd_pkg;

  localparam int unsigned CallDepthW = 6;
  localparam int unsigned DurW       = 48;
  localparam int unsigned TagW       = 32;

  localparam int unsigned MaxDepthDefault = 64;
  localparam int unsigned TimeBitsDefault = 48;

  typedef struct packed {
    logic                  window_start;
    logic [CallDepthW-1:0] call_depth;
    logic [DurW-1:0]       duration;
    logic [TagW-1:0]       entry_tag;
  } etd_in_t;

  typedef struct packed {
    logic [DurW-1:0] exclusive_time;
    logic [TagW-1:0] result_tag;
  } etd_out_t;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StCalc = 2'b10
  } etd_state_e;

endpackage

`default_nettype wire

>>> design/etd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none

module etd_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> design/etd_calc.sv
// Update arithmetic for one entry: saturating sibling sum, floored exclusive
// time and the new valid-bit vector. Depends on etd_pkg.
`default_nettype none

module etd_calc
  import etd_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = MaxDepthDefault,
  parameter int unsigned TIME_BITS = TimeBitsDefault
) (
  input  wire logic                         window_start_i,
  input  wire logic [$clog2(MAX_DEPTH)-1:0] depth_i,
  input  wire logic [$clog2(MAX_DEPTH)-1:0] prev_i,
  input  wire logic [DurW-1:0]              duration_i,
  input  wire logic [TIME_BITS-1:0]         sum_depth_i,
  input  wire logic [TIME_BITS-1:0]         sum_prev_i,
  input  wire logic [MAX_DEPTH-1:0]         valid_i,
  output logic      [TIME_BITS-1:0]         wr_data_o,
  output logic      [DurW-1:0]              excl_o,
  output logic      [MAX_DEPTH-1:0]         valid_o
);

  localparam int unsigned WideW = (TIME_BITS > DurW) ? TIME_BITS : DurW;

  logic [WideW-1:0]     dur_wide;
  logic [WideW-1:0]     time_max_wide;
  logic [TIME_BITS-1:0] dur;
  logic [TIME_BITS-1:0] sum_d;
  logic [TIME_BITS-1:0] sum_p;
  logic [TIME_BITS:0]   sat_sum;
  logic [TIME_BITS-1:0] sum_added;
  logic [TIME_BITS-1:0] excl;
  logic                 deeper;
  logic                 shallower;

  // Clamp the duration to the largest value the sums can hold
  assign dur_wide      = WideW'(duration_i);
  assign time_max_wide = WideW'({TIME_BITS{1'b1}});
  assign dur = (dur_wide > time_max_wide) ? {TIME_BITS{1'b1}} : TIME_BITS'(dur_wide);

  // Entries never written since the last clear read as zero
  assign sum_d = (valid_i[depth_i] && !window_start_i) ? sum_depth_i : '0;
  assign sum_p = valid_i[prev_i] ? sum_prev_i : '0;

  assign deeper    = depth_i > prev_i;
  assign shallower = depth_i < prev_i;

  assign sat_sum   = {1'b0, sum_d} + {1'b0, dur};
  assign sum_added = sat_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sat_sum[TIME_BITS-1:0];
  assign wr_data_o = deeper ? dur : sum_added;

  always_comb begin
    excl = dur;
    if (shallower) begin
      excl = (dur > sum_p) ? (dur - sum_p) : '0;
    end
  end
  assign excl_o = DurW'(excl);

  always_comb begin
    for (int k = 0; k < MAX_DEPTH; k++) begin
      if (window_start_i) begin
        valid_o[k] = (k == int'(depth_i));
      end else if (k == int'(depth_i)) begin
        valid_o[k] = 1'b1;
      end else if (deeper && (k > int'(prev_i)) && (k < int'(depth_i))) begin
        valid_o[k] = 1'b0;
      end else begin
        valid_o[k] = valid_i[k];
      end
    end
  end

endmodule

`default_nettype wire

>>> design/exclusive_time_by_depth.sv
// Channel   Direction  Payload     Handshake
// in        input      etd_in_t    in_valid_i / in_stall_o
// out       output     etd_out_t   out_valid_o / out_stall_i
//
// Entries are taken one at a time: both sum copies are read, then the entry
// is updated, written back and loaded into the result register before the
// next is taken, as the read-modify-write of the sum store requires. Reset
// clears the valid bits at once; no clearing pass. While a result is stalled
// the update step holds, and no new transaction is taken until it completes.
// Depends on etd_pkg, etd_ram and etd_calc.
`default_nettype none

module exclusive_time_by_depth
  import etd_pkg::*;
#(
  parameter int unsigned MAX_DEPTH = MaxDepthDefault,
  parameter int unsigned TIME_BITS = TimeBitsDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire etd_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output etd_out_t      out_data_o
);

  localparam int unsigned DepthW = $clog2(MAX_DEPTH);

  etd_state_e           state_q, state_d;
  logic [DepthW-1:0]    prev_q, prev_d;
  logic [MAX_DEPTH-1:0] valid_q, valid_d;
  logic                 out_valid_q, out_valid_d;
  etd_in_t              item_q;
  logic [DepthW-1:0]    depth_q;
  logic [DepthW-1:0]    pdepth_q;
  etd_out_t             out_data_q;

  logic                 accept;
  logic                 done;
  logic [DepthW-1:0]    in_depth;
  logic [DepthW-1:0]    in_prev;
  logic [TIME_BITS-1:0] rd_depth;
  logic [TIME_BITS-1:0] rd_prev;
  logic [TIME_BITS-1:0] wr_data;
  logic [DurW-1:0]      excl;
  logic [MAX_DEPTH-1:0] valid_new;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  // Leave the update cycle only once the result register is free
  assign done       = (state_q == StCalc) && (!out_valid_q || !out_stall_i);

  assign in_depth = (int'(in_data_i.call_depth) >= MAX_DEPTH) ?
                    DepthW'(MAX_DEPTH - 1) : DepthW'(in_data_i.call_depth);
  assign in_prev  = in_data_i.window_start ? in_depth : prev_q;

  // Two copies of the store, written alike, read at the entry's depth and
  // at the previous depth
  etd_ram #(.Width(TIME_BITS), .Depth(MAX_DEPTH)) u_ram_depth (
    .clk_i  (clk_i),
    .we_i   (done),
    .waddr_i(depth_q),
    .wdata_i(wr_data),
    .re_i   (accept),
    .raddr_i(in_depth),
    .rdata_o(rd_depth)
  );

  etd_ram #(.Width(TIME_BITS), .Depth(MAX_DEPTH)) u_ram_prev (
    .clk_i  (clk_i),
    .we_i   (done),
    .waddr_i(depth_q),
    .wdata_i(wr_data),
    .re_i   (accept),
    .raddr_i(in_prev),
    .rdata_o(rd_prev)
  );

  etd_calc #(.MAX_DEPTH(MAX_DEPTH), .TIME_BITS(TIME_BITS)) u_calc (
    .window_start_i(item_q.window_start),
    .depth_i       (depth_q),
    .prev_i        (pdepth_q),
    .duration_i    (item_q.duration),
    .sum_depth_i   (rd_depth),
    .sum_prev_i    (rd_prev),
    .valid_i       (valid_q),
    .wr_data_o     (wr_data),
    .excl_o        (excl),
    .valid_o       (valid_new)
  );

  always_comb begin
    state_d     = state_q;
    prev_d      = prev_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StCalc;
        end
      end
      StCalc: begin
        if (done) begin
          state_d     = StIdle;
          prev_d      = depth_q;
          valid_d     = valid_new;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      prev_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q   <= in_data_i;
      depth_q  <= in_depth;
      pdepth_q <= in_prev;
    end
    if (done) begin
      out_data_q.exclusive_time <= excl;
      out_data_q.result_tag     <= item_q.entry_tag;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_accept_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StCalc))
    else $error("accepted transaction did not enter the update cycle");

  a_result_from_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StCalc))
    else $error("result appeared without an update cycle");

  a_write_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> valid_q[$past(depth_q)])
    else $error("written depth not marked valid");

  a_prev_follows_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (prev_q == $past(depth_q)))
    else $error("previous depth not updated on write-back");

  a_no_write_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !done)
    else $error("store written while result register is held");
`endif

endmodule

`default_nettype wire

>>> bench/tb_exclusive_time_by_depth.sv
// Self-checking bench for exclusive_time_by_depth: predicts exclusive time per trace entry
// and compares each result transaction against it, under four idling phases.
// Depends on etd_pkg and the exclusive_time_by_depth RTL.
`timescale 1ns / 1ps

module tb_exclusive_time_by_depth
  import etd_pkg::*;
();

  localparam logic [DurW-1:0] TimeCeiling = '1;
  localparam int unsigned RandomPerPhase = 258;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  etd_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  etd_out_t out_data_o;

  exclusive_time_by_depth dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state: sibling sums per depth and the depth of the last entry
  logic [DurW-1:0]       sibling_sum [MaxDepthDefault];
  logic [CallDepthW-1:0] last_depth;

  etd_in_t  trace_entries [$];
  etd_out_t expected_times [$];
  etd_out_t oldest_time;

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int entries_sent = 0;
  int results_checked = 0;
  int window_starts = 0;
  int deeper_entries = 0;
  int shallower_entries = 0;
  int floored_results = 0;
  int saturated_adds = 0;

  function automatic logic [DurW-1:0] saturating_sum(logic [DurW-1:0] a, logic [DurW-1:0] b);
    logic [DurW:0] s;
    s = a + b;
    if (s[DurW]) begin
      saturated_adds++;
      return TimeCeiling;
    end
    return s[DurW-1:0];
  endfunction

  function automatic etd_out_t predict_exclusive(etd_in_t e);
    etd_out_t        r;
    logic [DurW-1:0] child;
    int              k;
    r.result_tag = e.entry_tag;
    if (e.window_start) begin
      window_starts++;
      for (k = 0; k < MaxDepthDefault; k++) sibling_sum[k] = '0;
      last_depth = e.call_depth;
    end
    if (e.call_depth == last_depth) begin
      sibling_sum[e.call_depth] = saturating_sum(sibling_sum[e.call_depth], e.duration);
      r.exclusive_time = e.duration;
    end else if (e.call_depth > last_depth) begin
      deeper_entries++;
      for (k = last_depth + 1; k < e.call_depth; k++) sibling_sum[k] = '0;
      sibling_sum[e.call_depth] = e.duration;
      r.exclusive_time = e.duration;
    end else begin
      shallower_entries++;
      child = sibling_sum[last_depth];
      if (e.duration > child) begin
        r.exclusive_time = e.duration - child;
      end else begin
        r.exclusive_time = '0;
        floored_results++;
      end
      sibling_sum[e.call_depth] = saturating_sum(sibling_sum[e.call_depth], e.duration);
    end
    last_depth = e.call_depth;
    return r;
  endfunction

  function automatic etd_in_t make_entry(bit ws, int depth, logic [DurW-1:0] dur,
                                         logic [TagW-1:0] tag);
    etd_in_t e;
    e.window_start = ws;
    e.call_depth   = depth[CallDepthW-1:0];
    e.duration     = dur;
    e.entry_tag    = tag;
    return e;
  endfunction

  // Append an entry to the tail of the pending queue
  function automatic void add_trace_entry(etd_in_t e);
    trace_entries.insert(trace_entries.size(), e);
  endfunction

  // Sender: hold a stalled transaction, otherwise offer the next entry or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_times.insert(expected_times.size(), predict_exclusive(in_data_i));
        entries_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (trace_entries.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_data_i  <= trace_entries.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_times.size() == 0) begin
        $display("%0t: unexpected result: exclusive_time %0d tag %h", $time,
                 out_data_o.exclusive_time, out_data_o.result_tag);
        mismatches++;
      end else begin
        oldest_time = expected_times.pop_front();
        if (out_data_o.exclusive_time !== oldest_time.exclusive_time) begin
          $display("%0t: exclusive_time expected %0d actual %0d (tag %h)", $time,
                   oldest_time.exclusive_time, out_data_o.exclusive_time,
                   oldest_time.result_tag);
          mismatches++;
        end
        if (out_data_o.result_tag !== oldest_time.result_tag) begin
          $display("%0t: result_tag expected %h actual %h", $time,
                   oldest_time.result_tag, out_data_o.result_tag);
          mismatches++;
        end
        results_checked++;
      end
    end
  end

  initial begin
    int              phase;
    int              i;
    int              walk;
    int              roll;
    bit              ws;
    bit              going_up;
    logic [DurW-1:0] dur;
    int              idle_by_phase [4];
    int              stall_by_phase [4];

    idle_by_phase  = '{0, 88, 0, 33};
    stall_by_phase = '{0, 0, 88, 33};
    for (i = 0; i < MaxDepthDefault; i++) sibling_sum[i] = '0;
    last_depth = '0;
    walk = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: nesting moves, range clearing, flooring, saturation, window starts
    add_trace_entry(make_entry(0, 0, 10, 32'h0));
    add_trace_entry(make_entry(0, 1, 5, 32'h1));
    add_trace_entry(make_entry(0, 1, 7, 32'h2));
    add_trace_entry(make_entry(0, 0, 100, 32'h3));
    add_trace_entry(make_entry(0, 3, 20, 32'h4));
    add_trace_entry(make_entry(0, 2, 50, 32'h5));
    add_trace_entry(make_entry(0, 1, 40, 32'h6));
    add_trace_entry(make_entry(0, 63, TimeCeiling, 32'h7));
    add_trace_entry(make_entry(0, 63, TimeCeiling, 32'h8));
    add_trace_entry(make_entry(0, 62, TimeCeiling, 32'h9));
    add_trace_entry(make_entry(0, 0, TimeCeiling, 32'hFFFF_FFFF));
    add_trace_entry(make_entry(0, 0, TimeCeiling, 32'hA));
    add_trace_entry(make_entry(1, 5, 1, 32'hB));
    add_trace_entry(make_entry(0, 4, 0, 32'hC));
    add_trace_entry(make_entry(1, 63, 123, 32'hD));
    add_trace_entry(make_entry(0, 0, 48'hAAAA_AAAA_AAAA, 32'h5555_5555));
    add_trace_entry(make_entry(1, 0, 48'h5555_5555_5555, 32'hAAAA_AAAA));
    add_trace_entry(make_entry(0, 1, 0, 32'hE));
    add_trace_entry(make_entry(0, 0, 0, 32'hF));
    add_trace_entry(make_entry(0, 2, 48'h8000_0000_0001, 32'h10));
    add_trace_entry(make_entry(0, 1, 48'h7FFF_FFFF_FFFF, 32'h11));
    add_trace_entry(make_entry(1, 63, TimeCeiling, 32'hFFFF_FFFF));

    for (phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_by_phase[phase];
      stall_pct = stall_by_phase[phase];
      // Mostly a call-stack walk; a few window starts and jumps as noise
      for (i = 0; i < RandomPerPhase; i++) begin
        roll = $urandom_range(99);
        ws = 1'b0;
        going_up = 1'b0;
        if (roll < 3) begin
          ws = 1'b1;
          walk = $urandom_range(63);
        end else if (roll < 48) begin
          if (walk < 63) walk = walk + 1;
        end else if (roll < 78) begin
          going_up = 1'b1;
          if (walk > 0) walk = walk - 1;
        end else if (roll >= 90) begin
          walk = $urandom_range(63);
        end
        roll = $urandom_range(99);
        if (roll < 55) dur = DurW'($urandom_range(going_up ? 5000 : 1000));
        else if (roll < 80) dur = DurW'($urandom);
        else if (roll < 93) dur = {16'($urandom), 32'($urandom)};
        else dur = TimeCeiling - DurW'($urandom_range(3));
        add_trace_entry(make_entry(ws, walk, dur, 32'($urandom)));
      end
      do @(negedge clk_i);
      while (trace_entries.size() != 0 || in_valid_i || expected_times.size() != 0);
    end

    repeat (20) @(posedge clk_i);
    $display("Sent %0d entries over four idling phases: %0d window starts,",
             entries_sent, window_starts);
    $display("%0d deeper, %0d shallower; checked %0d results, %0d floored at zero, %0d saturating additions.",
             deeper_entries, shallower_entries, results_checked, floored_results,
             saturated_adds);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d entries unsent and %0d results outstanding.",
             trace_entries.size(), expected_times.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> filelist.f
design/etd_pkg.sv
design/etd_ram.sv
design/etd_calc.sv
design/exclusive_time_by_depth.sv
bench/tb_exclusive_time_by_depth.sv
